// ----- rtl/core/wia_pkg.sv -----
package wia_pkg;

  localparam int unsigned WIDTH = 128;
  localparam int unsigned HALF  = 64;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef enum logic [4:0] {
    CMD_ADD = 5'd0,
    CMD_SUB = 5'd1,
    CMD_MUL = 5'd2,
    CMD_DIV = 5'd3,
    CMD_MOD = 5'd4,
    CMD_AND = 5'd5,
    CMD_OR  = 5'd6,
    CMD_XOR = 5'd7,
    CMD_NOT = 5'd8,
    CMD_SHL = 5'd9,
    CMD_SHR = 5'd10,
    CMD_EQ  = 5'd11,
    CMD_NE  = 5'd12,
    CMD_LT  = 5'd13,
    CMD_LE  = 5'd14,
    CMD_GT  = 5'd15,
    CMD_GE  = 5'd16
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_t;

endpackage

// ----- rtl/core/wia_addsub.sv -----
module wia_addsub (
  input  logic [wia_pkg::WIDTH-1:0] x,
  input  logic [wia_pkg::WIDTH-1:0] y,
  input  logic                      sub,
  output logic [wia_pkg::WIDTH-1:0] sum,
  output logic                      cout
);
  import wia_pkg::*;

  logic [WIDTH:0] total;

  // sub: x + ~y + 1, cout high means no borrow
  assign total = {1'b0, x} + {1'b0, y ^ {WIDTH{sub}}} + {{WIDTH{1'b0}}, sub};
  assign sum   = total[WIDTH-1:0];
  assign cout  = total[WIDTH];

endmodule

// ----- rtl/core/wia_seq.sv -----
module wia_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           iterative,
  input  logic           out_free,
  output logic           in_ready,
  output wia_pkg::ctrl_t ctrl
);
  import wia_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             last;

  assign last = (cnt == CNT_W'(WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (ctrl.load) begin
        cnt <= '0;
      end else if (ctrl.step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = iterative ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    ctrl.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      ST_RUN:  ctrl.step   = 1'b1;
      ST_DONE: ctrl.finish = out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/wide_integer_alu_128.sv -----
// Unsigned 128-bit ALU: add, sub, mul (low half), div, mod, logic ops, shifts and compares.
// One transaction in gives one transaction out. Multiply and divide/remainder with a nonzero
// divisor run one bit per cycle through a single shared 128-bit adder/subtractor; every
// other operation is computed directly from the loaded operands. A new transaction
// is taken only when the unit is idle, while a finished result may still sit in the output
// register. Divide by zero returns 0 with divide_by_zero set; remainder by zero returns A.
// Shifts of 128 or more return 0.
module wide_integer_alu_128 (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // a_high[63:0], a_low[127:64], b_high[191:128], b_low[255:192], shift_amount[263:256]
  input  logic [263:0] s_tdata,
  // command[4:0]
  input  logic [4:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_high[63:0], result_low[127:64], compare_true[128], divide_by_zero[129], zero fill
  output logic [135:0] m_tdata
);
  import wia_pkg::*;

  ctrl_t            ctrl;
  cmd_t             cmd_in;
  cmd_t             cmd;
  logic [7:0]       sh;
  logic             bz;
  logic             bz_in;
  logic             iterative;
  logic             out_free;
  logic [WIDTH-1:0] a_in;
  logic [WIDTH-1:0] b_in;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] opx;
  logic [WIDTH-1:0] opy;
  logic [WIDTH-1:0] add_x;
  logic [WIDTH-1:0] add_y;
  logic             add_sub;
  logic [WIDTH-1:0] sum;
  logic             cout;
  logic [WIDTH-1:0] rem_sh;
  logic             take;
  logic             eq;
  logic [WIDTH-1:0] res_val;
  logic             cmp_val;
  logic             dz_val;
  logic [WIDTH-1:0] res;
  logic             cmp_bit;
  logic             dz_bit;

  assign cmd_in    = cmd_t'(s_tuser);
  assign a_in      = {s_tdata[HALF-1:0], s_tdata[2*HALF-1:HALF]};
  assign b_in      = {s_tdata[3*HALF-1:2*HALF], s_tdata[4*HALF-1:3*HALF]};
  assign bz_in     = (b_in == '0);
  assign iterative = (cmd_in == CMD_MUL) ||
                     (((cmd_in == CMD_DIV) || (cmd_in == CMD_MOD)) && !bz_in);
  assign out_free  = !m_tvalid || m_tready;

  wia_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .iterative (iterative),
    .out_free  (out_free),
    .in_ready  (s_tready),
    .ctrl      (ctrl)
  );

  assign rem_sh = {acc[WIDTH-2:0], opx[WIDTH-1]};

  always_comb begin
    add_x   = opx;
    add_y   = opy;
    add_sub = (cmd != CMD_ADD);
    if (ctrl.step && (cmd == CMD_MUL)) begin
      add_x   = acc;
      add_y   = opx;
      add_sub = 1'b0;
    end else if (ctrl.step) begin
      add_x   = rem_sh;
      add_y   = opy;
      add_sub = 1'b1;
    end
  end

  wia_addsub u_addsub (
    .x    (add_x),
    .y    (add_y),
    .sub  (add_sub),
    .sum  (sum),
    .cout (cout)
  );

  // dropped top bit of the shifted remainder forces a subtract
  assign take = acc[WIDTH-1] || cout;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd <= cmd_in;
      sh  <= s_tdata[4*HALF+7:4*HALF];
      bz  <= bz_in;
      opx <= a_in;
      opy <= b_in;
      acc <= '0;
    end else if (ctrl.step) begin
      if (cmd == CMD_MUL) begin
        if (opy[0]) begin
          acc <= sum;
        end
        opx <= {opx[WIDTH-2:0], 1'b0};
        opy <= {1'b0, opy[WIDTH-1:1]};
      end else begin
        acc <= take ? sum : rem_sh;
        opx <= {opx[WIDTH-2:0], take};
      end
    end
  end

  assign eq = (opx == opy);

  always_comb begin
    res_val = '0;
    cmp_val = 1'b0;
    dz_val  = 1'b0;
    case (cmd)
      CMD_ADD, CMD_SUB: res_val = sum;
      CMD_MUL:          res_val = acc;
      CMD_DIV: begin
        dz_val  = bz;
        res_val = bz ? '0 : opx;
      end
      CMD_MOD: res_val = bz ? opx : acc;
      CMD_AND: res_val = opx & opy;
      CMD_OR:  res_val = opx | opy;
      CMD_XOR: res_val = opx ^ opy;
      CMD_NOT: res_val = ~opx;
      CMD_SHL: res_val = sh[7] ? '0 : (opx << sh[CNT_W-1:0]);
      CMD_SHR: res_val = sh[7] ? '0 : (opx >> sh[CNT_W-1:0]);
      CMD_EQ:  cmp_val = eq;
      CMD_NE:  cmp_val = !eq;
      CMD_LT:  cmp_val = !cout;
      CMD_LE:  cmp_val = !cout || eq;
      CMD_GT:  cmp_val = cout && !eq;
      CMD_GE:  cmp_val = cout;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      res     <= res_val;
      cmp_bit <= cmp_val;
      dz_bit  <= dz_val;
    end
  end

  assign m_tdata = {6'b0, dz_bit, cmp_bit, res[HALF-1:0], res[WIDTH-1:HALF]};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("unit ready right after accepting a transaction");

  a_dz_no_compare: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[129]) |-> !m_tdata[128])
    else $error("divide by zero flagged together with a compare outcome");

  a_dz_zero_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[129]) |-> (m_tdata[127:0] == '0))
    else $error("divide by zero with nonzero result");

  a_finish_needs_slot: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> (!m_tvalid || m_tready))
    else $error("result written over an untaken transaction");

endmodule
